@@ hdl/polygon_center_and_bound_radius_core_defines.svh @@
// Assertion macros shared by the core's modules
`ifndef POLYGON_CENTER_AND_BOUND_RADIUS_CORE_DEFINES_SVH
`define POLYGON_CENTER_AND_BOUND_RADIUS_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset
`define PCBR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold on the edge after the trigger
`define PCBR_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

@@ hdl/pcbr_pkg.sv @@
package pcbr_pkg;

    localparam int MAX_VERTS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int RAD_W         = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int SQRT_STEPS    = 32;

    typedef enum logic [1:0] {
        KIND_POINT,
        KIND_SEGMENT,
        KIND_BOX,
        KIND_POLY
    } shape_kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_GIVEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_GIVEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd4;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RD0,
        S_V0,
        S_RDK,
        S_VK,
        S_PRESET,
        S_DIVI,
        S_DIVS,
        S_DIVE,
        S_RDI,
        S_DIFF,
        S_MUL,
        S_ACC,
        S_SQI,
        S_SQS,
        S_FIN
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_READ,
        OP_V0,
        OP_VK,
        OP_PRESET,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_DIFF,
        OP_MUL,
        OP_ACC_SEG,
        OP_ACC_MAX,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load;
    } dp_cmd_t;

    typedef struct packed {
        shape_kind_t kind;
        logic        center_given;
        logic        radius_given;
        logic        out_free;
    } dp_status_t;

endpackage

@@ hdl/vertex_if.sv @@
interface vertex_if
    import pcbr_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  vertex_x;
    logic signed [COORD_W-1:0]  vertex_y;
    logic [1:0]                 shape_kind;
    logic                       last_vertex;

    modport source (output valid, vertex_x, vertex_y, shape_kind, last_vertex, input ready);
    modport sink (input valid, vertex_x, vertex_y, shape_kind, last_vertex, output ready);
endinterface

@@ hdl/result_if.sv @@
interface result_if
    import pcbr_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  mid_x;
    logic signed [COORD_W-1:0]  mid_y;
    logic [RAD_W-1:0]           bound_radius;
    logic                       empty_error;

    modport source (output valid, mid_x, mid_y, bound_radius, empty_error, input ready);
    modport sink (input valid, mid_x, mid_y, bound_radius, empty_error, output ready);
endinterface

@@ hdl/cfg_if.sv @@
interface cfg_if
    import pcbr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [31:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/pcbr_ram.sv @@
module pcbr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ hdl/pcbr_ctrl.sv @@
`include "polygon_center_and_bound_radius_core_defines.svh"
module pcbr_ctrl
    import pcbr_pkg::*;
#(
    parameter int MAX_VERTS = MAX_VERTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_last,
    output logic                             in_ready,
    input  dp_status_t                       status,
    input  logic [$clog2(MAX_VERTS+1)-1:0]   count,
    output dp_cmd_t                          cmd,
    output logic [$clog2(MAX_VERTS)-1:0]     rd_addr
);
    localparam int IDXW = $clog2(MAX_VERTS);
    localparam int CNTW = $clog2(MAX_VERTS + 1);
    localparam int SUMW = COORD_W + CNTW;
    localparam int ITW  = $clog2(SUMW + 1);

    ctrl_state_t      state_reg, state_next;
    logic [ITW-1:0]   it_reg, it_next;
    logic [CNTW-1:0]  idx_reg, idx_next;
    logic [CNTW-1:0]  idx_inc;

    assign idx_inc = idx_reg + CNTW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            it_reg    <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            it_reg    <= it_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:   if (in_valid && in_last) state_next = S_RD0;
            S_RD0:    state_next = S_V0;
            S_V0:
            begin
                case (status.kind)
                    KIND_POINT:   state_next = S_FIN;
                    KIND_SEGMENT,
                    KIND_BOX:     state_next = S_RDK;
                    default:
                    begin
                        if (status.center_given)
                            state_next = S_PRESET;
                        else if (count == '0)
                            state_next = S_FIN;
                        else
                            state_next = S_DIVI;
                    end
                endcase
            end
            S_RDK:    state_next = S_VK;
            S_VK:     state_next = status.radius_given ? S_FIN : S_DIFF;
            S_PRESET: state_next = status.radius_given ? S_FIN : S_RDI;
            S_DIVI:   state_next = S_DIVS;
            S_DIVS:   if (it_reg == ITW'(SUMW - 1)) state_next = S_DIVE;
            S_DIVE:   state_next = status.radius_given ? S_FIN : S_RDI;
            S_RDI:    state_next = S_DIFF;
            S_DIFF:   state_next = S_MUL;
            S_MUL:    state_next = S_ACC;
            S_ACC:
            begin
                if (status.kind == KIND_POLY && idx_inc < count)
                    state_next = S_RDI;
                else
                    state_next = S_SQI;
            end
            S_SQI:    state_next = S_SQS;
            S_SQS:    if (it_reg == ITW'(SQRT_STEPS - 1)) state_next = S_FIN;
            S_FIN:    if (status.out_free) state_next = S_LOAD;
            default:  state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_IDLE;
        cmd.load = 1'b0;
        in_ready = 1'b0;
        rd_addr  = idx_reg[IDXW-1:0];
        it_next  = it_reg;
        idx_next = idx_reg;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_RD0:
            begin
                cmd.op  = OP_READ;
                rd_addr = '0;
            end
            S_V0:
            begin
                cmd.op   = OP_V0;
                idx_next = '0;
            end
            S_RDK:
            begin
                cmd.op  = OP_READ;
                rd_addr = (status.kind == KIND_SEGMENT) ? IDXW'(1) : IDXW'(2);
            end
            S_VK:     cmd.op = OP_VK;
            S_PRESET: cmd.op = OP_PRESET;
            S_DIVI:
            begin
                cmd.op  = OP_DIV_INIT;
                it_next = '0;
            end
            S_DIVS:
            begin
                cmd.op  = OP_DIV_STEP;
                it_next = it_reg + ITW'(1);
            end
            S_DIVE:   cmd.op = OP_DIV_END;
            S_RDI:    cmd.op = OP_READ;
            S_DIFF:   cmd.op = OP_DIFF;
            S_MUL:    cmd.op = OP_MUL;
            S_ACC:
            begin
                if (status.kind == KIND_POLY)
                begin
                    cmd.op   = OP_ACC_MAX;
                    idx_next = idx_inc;
                end
                else
                begin
                    cmd.op = OP_ACC_SEG;
                end
            end
            S_SQI:
            begin
                cmd.op  = OP_SQRT_INIT;
                it_next = '0;
            end
            S_SQS:
            begin
                cmd.op  = OP_SQRT_STEP;
                it_next = it_reg + ITW'(1);
            end
            S_FIN:    if (status.out_free) cmd.op = OP_FINISH;
            default:  cmd.op = OP_IDLE;
        endcase
    end

    `PCBR_ASSERT_NEXT(a_last_starts, state_reg == S_LOAD && in_valid && in_last, state_reg == S_RD0, "last vertex did not start the result")
    `PCBR_ASSERT_NEXT(a_fin_holds, state_reg == S_FIN && !status.out_free, state_reg == S_FIN, "result dropped while output busy")
    `PCBR_ASSERT(a_loop_bound, idx_reg <= CNTW'(MAX_VERTS), "vertex scan ran past the store")
endmodule

@@ hdl/pcbr_datapath.sv @@
`include "polygon_center_and_bound_radius_core_defines.svh"
module pcbr_datapath
    import pcbr_pkg::*;
#(
    parameter int MAX_VERTS = MAX_VERTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic signed [COORD_W-1:0]        vertex_x,
    input  logic signed [COORD_W-1:0]        vertex_y,
    input  logic [1:0]                       shape_kind,
    input  logic                             last_vertex,
    input  dp_cmd_t                          cmd,
    input  logic [$clog2(MAX_VERTS)-1:0]     rd_addr,
    output dp_status_t                       status,
    output logic [$clog2(MAX_VERTS+1)-1:0]   count,
    cfg_if.sink                              cfg,
    result_if.source                         res
);
    localparam int IDXW = $clog2(MAX_VERTS);
    localparam int CNTW = $clog2(MAX_VERTS + 1);
    localparam int SUMW = COORD_W + CNTW;
    localparam int SQW  = 2 * COORD_W;

    // configuration
    logic                       cg_reg, rg_reg;
    logic signed [COORD_W-1:0]  pc_reg [2];
    logic [RAD_W-1:0]           prad_reg;

    logic [CNTW-1:0]            count_reg;
    logic signed [SUMW-1:0]     sum_reg [2];
    shape_kind_t                kind_reg;

    logic signed [COORD_W-1:0]  ref_reg [2];
    logic signed [COORD_W-1:0]  ctr_reg [2];
    logic [SUMW-1:0]            dv_reg [2];
    logic [SUMW-1:0]            q_reg [2];
    logic [CNTW:0]              rem_reg [2];
    logic                       neg_reg [2];
    logic [COORD_W-1:0]         ad_reg [2];
    logic [SQW-1:0]             sq_reg [2];
    logic [SQW-1:0]             max_reg;
    logic [SQW-1:0]             n_reg, root_reg, bit_reg;

    logic                       ovld_reg;
    logic signed [COORD_W-1:0]  omid_reg [2];
    logic [RAD_W-1:0]           orad_reg;
    logic                       oerr_reg;

    logic                       store_en;
    logic [SQW-1:0]             wdata, rdata;
    logic signed [COORD_W-1:0]  rd_c [2];
    logic signed [COORD_W-1:0]  in_c [2];
    logic [SQW:0]               d2;
    logic [SQW-1:0]             dsat;
    logic [SQW:0]               trial;
    logic                       empty;
    logic                       out_free;

    assign in_c[0]  = vertex_x;
    assign in_c[1]  = vertex_y;
    assign store_en = cmd.load && (count_reg < CNTW'(MAX_VERTS));
    assign wdata    = {vertex_y, vertex_x};
    assign rd_c[0]  = rdata[COORD_W-1:0];
    assign rd_c[1]  = rdata[SQW-1:COORD_W];
    assign d2       = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
    assign dsat     = d2[SQW] ? '1 : d2[SQW-1:0];
    assign trial    = {1'b0, root_reg} + {1'b0, bit_reg};
    assign empty    = (kind_reg == KIND_POLY) && !cg_reg && (count_reg == '0);
    assign out_free = !ovld_reg || res.ready;

    pcbr_ram #(
        .WIDTH (SQW),
        .DEPTH (MAX_VERTS)
    ) u_store (
        .clk   (clk),
        .we    (store_en),
        .waddr (count_reg[IDXW-1:0]),
        .wdata (wdata),
        .re    (cmd.op == OP_READ),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cg_reg    <= 1'b0;
            rg_reg    <= 1'b0;
            pc_reg[0] <= '0;
            pc_reg[1] <= '0;
            prad_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CENTER_GIVEN: cg_reg    <= cfg.data[0];
                CFG_CENTER_X:     pc_reg[0] <= cfg.data;
                CFG_CENTER_Y:     pc_reg[1] <= cfg.data;
                CFG_RADIUS_GIVEN: rg_reg    <= cfg.data[0];
                CFG_RADIUS:       prad_reg  <= cfg.data;
                default:          ;
            endcase
        end
    end

    // per-polygon accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            kind_reg   <= KIND_POINT;
            max_reg    <= '0;
        end
        else
        begin
            if (store_en)
            begin
                count_reg <= count_reg + CNTW'(1);
                for (int a = 0; a < 2; a++)
                    sum_reg[a] <= sum_reg[a] + SUMW'(in_c[a]);
            end
            if (cmd.load && last_vertex)
                kind_reg <= shape_kind_t'(shape_kind);
            case (cmd.op)
                OP_ACC_SEG: max_reg <= {1'b0, d2[SQW:2]};
                OP_ACC_MAX: if (dsat > max_reg) max_reg <= dsat;
                OP_FINISH:
                begin
                    count_reg  <= '0;
                    sum_reg[0] <= '0;
                    sum_reg[1] <= '0;
                    max_reg    <= '0;
                end
                default: ;
            endcase
        end
    end

    // centre, divider, distance and root
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 2; a++)
        begin
            logic signed [COORD_W:0] pair;
            logic [CNTW:0]           rsh;
            logic [SUMW-1:0]         qs;
            pair = {ref_reg[a][COORD_W-1], ref_reg[a]} + {rd_c[a][COORD_W-1], rd_c[a]};
            rsh  = {rem_reg[a][CNTW-1:0], dv_reg[a][SUMW-1]};
            qs   = neg_reg[a] ? -q_reg[a] : q_reg[a];
            case (cmd.op)
                OP_V0:
                begin
                    ref_reg[a] <= rd_c[a];
                    ctr_reg[a] <= rd_c[a];
                end
                OP_VK:
                begin
                    // halve, truncating toward zero
                    pair       = pair + (COORD_W+1)'(pair[COORD_W]);
                    ctr_reg[a] <= pair[COORD_W:1];
                end
                OP_PRESET:
                begin
                    ref_reg[a] <= pc_reg[a];
                    ctr_reg[a] <= pc_reg[a];
                end
                OP_DIV_INIT:
                begin
                    neg_reg[a] <= sum_reg[a][SUMW-1];
                    dv_reg[a]  <= sum_reg[a][SUMW-1] ? -sum_reg[a] : sum_reg[a];
                    q_reg[a]   <= '0;
                    rem_reg[a] <= '0;
                end
                OP_DIV_STEP:
                begin
                    dv_reg[a] <= dv_reg[a] << 1;
                    if (rsh >= {1'b0, count_reg})
                    begin
                        rem_reg[a] <= rsh - {1'b0, count_reg};
                        q_reg[a]   <= {q_reg[a][SUMW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[a] <= rsh;
                        q_reg[a]   <= {q_reg[a][SUMW-2:0], 1'b0};
                    end
                end
                OP_DIV_END:
                begin
                    ref_reg[a] <= qs[COORD_W-1:0];
                    ctr_reg[a] <= qs[COORD_W-1:0];
                end
                OP_DIFF:
                begin
                    pair      = {ref_reg[a][COORD_W-1], ref_reg[a]}
                              - {rd_c[a][COORD_W-1], rd_c[a]};
                    ad_reg[a] <= pair[COORD_W] ? COORD_W'(-pair) : pair[COORD_W-1:0];
                end
                OP_MUL:   sq_reg[a] <= ad_reg[a] * ad_reg[a];
                default:  ;
            endcase
        end
        case (cmd.op)
            OP_SQRT_INIT:
            begin
                n_reg    <= max_reg;
                root_reg <= '0;
                bit_reg  <= SQW'(1) << (SQW - 2);
            end
            OP_SQRT_STEP:
            begin
                if ({1'b0, n_reg} >= trial)
                begin
                    n_reg    <= n_reg - trial[SQW-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default: ;
        endcase
    end

    // output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (cmd.op == OP_FINISH)
        begin
            ovld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            ovld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FINISH)
        begin
            omid_reg[0] <= empty ? '0 : ctr_reg[0];
            omid_reg[1] <= empty ? '0 : ctr_reg[1];
            oerr_reg    <= empty;
            if (kind_reg == KIND_POINT || empty)
                orad_reg <= '0;
            else if (rg_reg)
                orad_reg <= prad_reg;
            else
                orad_reg <= root_reg[RAD_W-1:0];
        end
    end

    assign res.valid        = ovld_reg;
    assign res.mid_x        = omid_reg[0];
    assign res.mid_y        = omid_reg[1];
    assign res.bound_radius = orad_reg;
    assign res.empty_error  = oerr_reg;

    assign status.kind         = kind_reg;
    assign status.center_given = cg_reg;
    assign status.radius_given = rg_reg;
    assign status.out_free     = out_free;
    assign count               = count_reg;

    `PCBR_ASSERT(a_count_bound, count_reg <= CNTW'(MAX_VERTS), "vertex count past the store depth")
    `PCBR_ASSERT_NEXT(a_finish_valid, cmd.op == OP_FINISH, ovld_reg, "finished result not presented")
    `PCBR_ASSERT_NEXT(a_finish_clears, cmd.op == OP_FINISH, count_reg == '0, "vertex count not cleared")
endmodule

@@ hdl/polygon_center_and_bound_radius_core.sv @@
// Polygon centre and bounding radius. Vertices are taken one word per cycle on vtx while
// the core is loading and stored in a vertex RAM; the word with last_vertex set starts the
// result, which leaves on res as one word. A point is presented once its vertex is read
// back; a segment or box takes the midpoint, one squared distance, then a 32-step
// bit-per-cycle square root, or only the midpoint with a preset radius. A multi-edge
// polygon of N stored vertices takes a preset centre or the vertex mean (bit-serial
// divider), then a scan over the vertex RAM (single read port, one multiply stage per
// vertex) and the root; with a preset radius the scan and root are skipped.
// A busy output register holds the core in its final state until the register frees.
// Loading of the next polygon starts as soon as the result sits in the output register.
module polygon_center_and_bound_radius_core
    import pcbr_pkg::*;
#(
    parameter int MAX_VERTS = MAX_VERTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    vertex_if.sink     vtx,
    cfg_if.sink        cfg,
    result_if.source   res
);
    localparam int IDXW = $clog2(MAX_VERTS);
    localparam int CNTW = $clog2(MAX_VERTS + 1);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [CNTW-1:0]  count;
    logic [IDXW-1:0]  rd_addr;
    logic             in_ready;

    assign vtx.ready = in_ready;

    pcbr_ctrl #(
        .MAX_VERTS (MAX_VERTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vtx.valid),
        .in_last  (vtx.last_vertex),
        .in_ready (in_ready),
        .status   (status),
        .count    (count),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    pcbr_datapath #(
        .MAX_VERTS (MAX_VERTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .vertex_x    (vtx.vertex_x),
        .vertex_y    (vtx.vertex_y),
        .shape_kind  (vtx.shape_kind),
        .last_vertex (vtx.last_vertex),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .status      (status),
        .count       (count),
        .cfg         (cfg),
        .res         (res)
    );
endmodule
